// File: design/vln_pkg.sv
// ----------------------------------------------------------------------------
// vln_pkg
// Shared constants and types for the vector L2 normalizer.
// ----------------------------------------------------------------------------
package vln_pkg;

   localparam int MAX_LEN    = 64;                  // elements per vector, 1..64
   localparam int ADDR_W     = 6;                   // element store address
   localparam int CNT_W      = $clog2(MAX_LEN + 1); // element count, holds MAX_LEN
   localparam int VAL_W      = 16;                  // element and result width
   localparam int SQ_W       = 2 * VAL_W;           // one squared magnitude
   localparam int SUM_W      = 38;                  // sum of squares, padded to pairs
   localparam int ROOT_W     = 27;                  // norm in Q.20
   localparam int REM_W      = 28;                  // shared remainder register
   localparam int ALU_W      = 30;                  // shared subtractor width
   localparam int STEP_W     = 5;                   // iteration counter
   localparam int SQRT_STEPS = 27;                  // bit pairs of sum * 2^16
   localparam int DIV_STEPS  = 15;                  // quotient bits below saturation
   localparam int SAT_SHIFT  = 8;                   // |x| * 2^8 >= q means saturation

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = CSR_ADDR_W - 2;

   localparam logic [CSR_IDX_W-1:0] CSR_IDX_ENABLE = CSR_IDX_W'(0);

   localparam logic [VAL_W-2:0] SAT_MAG = {(VAL_W-1){1'b1}};

   typedef struct packed {
      logic [ALU_W-1:0] minuend;
      logic [ALU_W-1:0] subtrahend;
   } vln_alu_req_type;

   typedef struct packed {
      logic [ALU_W-1:0] diff;
      logic             ge;
   } vln_alu_rsp_type;

endpackage

// File: design/vln_ifs.sv
// ----------------------------------------------------------------------------
// vln_ifs
// Valid/ready channels for element input and result output.
// ----------------------------------------------------------------------------
interface vln_req_if import vln_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [VAL_W-1:0] element_value;
   logic                    last_element;

   modport source (output valid, element_value, last_element, input ready);
   modport sink   (input valid, element_value, last_element, output ready);
endinterface

interface vln_rsp_if import vln_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [VAL_W-1:0] result_value;
   logic [ADDR_W-1:0]       result_index;
   logic                    was_scaled;
   logic                    last_result;

   modport source (output valid, result_value, result_index, was_scaled, last_result,
                   input ready);
   modport sink   (input valid, result_value, result_index, was_scaled, last_result,
                   output ready);
endinterface

// File: design/vln_csr.sv
// ----------------------------------------------------------------------------
// vln_csr
// APB register block: holds the normalize enable bit.
// ----------------------------------------------------------------------------
module vln_csr import vln_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output logic                  normalize_enable
);

   logic                 enable_ff;
   logic                 enable_in;
   logic [CSR_IDX_W-1:0] reg_idx;
   logic                 wr_en;

   assign reg_idx = paddr[CSR_ADDR_W-1:2];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;

   always_comb begin
      enable_in = enable_ff;
      if (wr_en && (reg_idx == CSR_IDX_ENABLE)) begin
         enable_in = pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff <= 1'b1;
      end else begin
         enable_ff <= enable_in;
      end
   end

   assign prdata           = (reg_idx == CSR_IDX_ENABLE) ? CSR_DATA_W'(enable_ff) : '0;
   assign normalize_enable = enable_ff;

endmodule

// File: design/vln_alu.sv
// ----------------------------------------------------------------------------
// vln_alu
// Shared trial subtractor for the square root, the saturation check and the divide iterations.
// ----------------------------------------------------------------------------
module vln_alu import vln_pkg::*; (
   input  vln_alu_req_type alu_req,
   output vln_alu_rsp_type alu_rsp
);

   logic [ALU_W:0] diff_wide;

   assign diff_wide    = {1'b0, alu_req.minuend} - {1'b0, alu_req.subtrahend};
   assign alu_rsp.diff = diff_wide[ALU_W-1:0];
   assign alu_rsp.ge   = ~diff_wide[ALU_W];

endmodule

// File: design/vector_l2_normalizer.sv
// ----------------------------------------------------------------------------
// vector_l2_normalizer
// Buffers a vector, takes its L2 norm, and emits each element scaled to Q1.15,
// or unchanged when scaling is off or the sum is zero.
// Input: one element per cycle while collecting (ready high in that phase).
// Vector end: square root over SQRT_STEPS bit pairs on the shared subtractor,
//   skipped when scaling is off or the sum is zero.
// Per result: fetch, load, 15 divide steps and output when scaled and not
//   saturated, else fetch, load and output; output waits out any rsp stall.
// Reset: control state clears, normalize_enable goes to 1; store contents are
//   left as they are and need no clearing pass.
// ----------------------------------------------------------------------------
module vector_l2_normalizer import vln_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   vln_req_if.sink               req_ch,
   vln_rsp_if.source             rsp_ch,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   typedef enum logic [2:0] {
      S_ACCUM,
      S_SQRT,
      S_FETCH,
      S_LOAD,
      S_DIV,
      S_EMIT
   } state_type;

   state_type                  state_ff, state_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [SUM_W-1:0]           sum_ff, sum_in;
   logic [CNT_W-1:0]           n_ff, n_in;
   logic [ADDR_W-1:0]          k_ff, k_in;
   logic [STEP_W-1:0]          step_ff, step_in;
   logic                       scale_ff, scale_in;
   logic                       out_valid_ff, out_valid_in;
   logic [ROOT_W-1:0]          root_ff, root_in;
   logic [REM_W-1:0]           rem_ff, rem_in;
   logic [DIV_STEPS-1:0]       quot_ff, quot_in;
   logic                       neg_ff, neg_in;
   logic signed [VAL_W-1:0]    out_value_ff, out_value_in;
   logic                       out_last_ff, out_last_in;

   logic signed [VAL_W-1:0]    store_mem [2**ADDR_W];
   logic signed [VAL_W-1:0]    rd_ff;
   logic                       mem_we;
   logic                       mem_re;

   logic                       normalize_enable;
   logic                       accept;
   logic [VAL_W-1:0]           in_mag;
   logic [SQ_W-1:0]            in_sq;
   logic [SUM_W-1:0]           sum_add;
   logic [CNT_W-1:0]           count_inc;
   logic [VAL_W-1:0]           rd_mag;
   logic [DIV_STEPS-1:0]       quot_final;
   logic                       last_k;
   logic                       emit_now;
   logic signed [VAL_W-1:0]    emit_value;

   vln_alu_req_type            alu_req;
   vln_alu_rsp_type            alu_rsp;

   vln_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready),
      .normalize_enable (normalize_enable)
   );

   vln_alu u_alu (
      .alu_req (alu_req),
      .alu_rsp (alu_rsp)
   );

   assign req_ch.ready = (state_ff == S_ACCUM);
   assign accept       = req_ch.valid && req_ch.ready;

   assign in_mag     = req_ch.element_value[VAL_W-1] ? VAL_W'(-req_ch.element_value)
                                                     : VAL_W'(req_ch.element_value);
   assign in_sq      = in_mag * in_mag;
   assign sum_add    = sum_ff + SUM_W'(in_sq);
   assign count_inc  = count_ff + CNT_W'(1);
   assign rd_mag     = rd_ff[VAL_W-1] ? VAL_W'(-rd_ff) : VAL_W'(rd_ff);
   assign quot_final = {quot_ff[DIV_STEPS-2:0], alu_rsp.ge};
   assign last_k     = ((CNT_W'(k_ff) + CNT_W'(1)) == n_ff);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      n_in         = n_ff;
      k_in         = k_ff;
      step_in      = step_ff;
      scale_in     = scale_ff;
      out_valid_in = out_valid_ff;
      root_in      = root_ff;
      rem_in       = rem_ff;
      quot_in      = quot_ff;
      neg_in       = neg_ff;
      out_value_in = out_value_ff;
      out_last_in  = out_last_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      emit_now     = 1'b0;
      emit_value   = rd_ff;
      alu_req      = '0;

      case (state_ff)
         S_ACCUM: begin
            if (accept) begin
               mem_we   = 1'b1;
               count_in = count_inc;
               sum_in   = sum_add;
               if (req_ch.last_element || (count_inc == CNT_W'(MAX_LEN))) begin
                  n_in     = count_inc;
                  count_in = '0;
                  k_in     = '0;
                  step_in  = '0;
                  root_in  = '0;
                  rem_in   = '0;
                  scale_in = normalize_enable && (sum_add != '0);
                  if (normalize_enable && (sum_add != '0)) begin
                     state_in = S_SQRT;
                  end else begin
                     sum_in   = '0;
                     state_in = S_FETCH;
                  end
               end
            end
         end
         S_SQRT: begin
            // one root bit per step: bring down the next bit pair of sum * 2^16
            alu_req.minuend    = {rem_ff, sum_ff[SUM_W-1 -: 2]};
            alu_req.subtrahend = ALU_W'({root_ff, 2'b01});
            rem_in  = alu_rsp.ge ? alu_rsp.diff[REM_W-1:0]
                                 : REM_W'({rem_ff, sum_ff[SUM_W-1 -: 2]});
            root_in = {root_ff[ROOT_W-2:0], alu_rsp.ge};
            sum_in  = {sum_ff[SUM_W-3:0], 2'b00};   // empties the sum by the last step
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(SQRT_STEPS - 1)) begin
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            mem_re   = 1'b1;
            state_in = S_LOAD;
         end
         S_LOAD: begin
            alu_req.minuend    = ALU_W'({rd_mag, {SAT_SHIFT{1'b0}}});
            alu_req.subtrahend = ALU_W'(root_ff);
            if (!scale_ff) begin
               emit_now   = 1'b1;
               emit_value = rd_ff;
            end else if (alu_rsp.ge) begin
               // quotient would exceed the Q1.15 range
               emit_now   = 1'b1;
               emit_value = rd_ff[VAL_W-1] ? -$signed({1'b0, SAT_MAG})
                                           : $signed({1'b0, SAT_MAG});
            end else begin
               rem_in   = REM_W'({rd_mag, {SAT_SHIFT{1'b0}}});
               quot_in  = '0;
               step_in  = '0;
               neg_in   = rd_ff[VAL_W-1];
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            alu_req.minuend    = ALU_W'({rem_ff, 1'b0});
            alu_req.subtrahend = ALU_W'(root_ff);
            rem_in  = alu_rsp.ge ? alu_rsp.diff[REM_W-1:0] : {rem_ff[REM_W-2:0], 1'b0};
            quot_in = quot_final;
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
               emit_now   = 1'b1;
               emit_value = neg_ff ? -$signed({1'b0, quot_final})
                                   : $signed({1'b0, quot_final});
            end
         end
         S_EMIT: begin
            if (rsp_ch.ready) begin
               out_valid_in = 1'b0;
               if (out_last_ff) begin
                  state_in = S_ACCUM;
               end else begin
                  k_in     = k_ff + ADDR_W'(1);
                  state_in = S_FETCH;
               end
            end
         end
         default: begin
            state_in = S_ACCUM;
         end
      endcase

      if (emit_now) begin
         out_valid_in = 1'b1;
         out_value_in = emit_value;
         out_last_in  = last_k;
         state_in     = S_EMIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_ACCUM;
         count_ff     <= '0;
         sum_ff       <= '0;
         n_ff         <= '0;
         k_ff         <= '0;
         step_ff      <= '0;
         scale_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         sum_ff       <= sum_in;
         n_ff         <= n_in;
         k_ff         <= k_in;
         step_ff      <= step_in;
         scale_ff     <= scale_in;
         out_valid_ff <= out_valid_in;
      end
      root_ff      <= root_in;
      rem_ff       <= rem_in;
      quot_ff      <= quot_in;
      neg_ff       <= neg_in;
      out_value_ff <= out_value_in;
      out_last_ff  <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[count_ff[ADDR_W-1:0]] <= req_ch.element_value;
      end
      if (mem_re) begin
         rd_ff <= store_mem[k_ff];
      end
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.result_value = out_value_ff;
   assign rsp_ch.result_index = k_ff;
   assign rsp_ch.was_scaled   = scale_ff;
   assign rsp_ch.last_result  = out_last_ff;

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ch.ready && rsp_ch.valid))
      else $error("input accepted while a result is pending");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff < CNT_W'(MAX_LEN))
      else $error("element count passed vector limit");

   a_rem_below_q: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (rem_ff < REM_W'(root_ff)))
      else $error("divide remainder not below norm");

   a_scaled_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.was_scaled) |-> (rsp_ch.result_value != {1'b1, {(VAL_W-1){1'b0}}}))
      else $error("scaled result outside saturation range");

   a_sum_cleared: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT) |-> (sum_ff == '0))
      else $error("sum of squares not cleared before output");

endmodule

// File: tb/sv/tb_vector_l2_normalizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vector_l2_normalizer
// Drives signed Q4.12 vectors into the normalizer and checks every result
// beat against a cycle-free predictor of the norm, the division and the
// saturation. Both channels idle and stall in random bursts. The enable
// register is rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb_vector_l2_normalizer;
   import vln_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = 40;
   localparam logic [CSR_ADDR_W-1:0] ENABLE_ADDR = {CSR_IDX_ENABLE, 2'b00};
   localparam logic [CSR_ADDR_W-1:0] SPARE_ADDR  = {CSR_IDX_W'(1), 2'b00};

   typedef struct packed {
      logic [VAL_W-1:0] value;
      logic             last;
   } element_beat_type;

   typedef struct packed {
      logic [VAL_W-1:0]  value;
      logic [ADDR_W-1:0] index;
      logic              scaled;
      logic              last;
   } norm_result_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  psel = 1'b0;
   logic                  penable = 1'b0;
   logic                  pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   vln_req_if req_if ();
   vln_rsp_if rsp_if ();

   vector_l2_normalizer u_top (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_if),
      .rsp_ch  (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   element_beat_type element_queue[$];
   norm_result_type  result_due[$];
   logic [VAL_W-1:0] vector_buf[$];
   logic [36:0]      sum_sq = '0;
   bit               norm_en = 1'b1;
   bit               idle_on = 1'b1;
   int               mismatches = 0;
   int               cycle_count = 0;
   int               req_gap = 0;
   int               rsp_stall = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      if (mismatches < 50)
         $display("[%0t] MISMATCH: %s", $realtime, msg);
      mismatches++;
   endtask

   function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
      logic [63:0] root;
      logic [63:0] trial;
      root = '0;
      for (int b = 27; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= v)
            root = trial;
      end
      return root;
   endfunction

   // Buffer one element; on the vector end, queue the expected results of the whole vector, scaled or passed through.
   task automatic absorb_element(input logic [VAL_W-1:0] raw, input logic last_flag);
      int              xi;
      int              n;
      logic [63:0]     mag;
      logic [63:0]     norm_q20;
      logic [63:0]     quot;
      bit              do_scale;
      norm_result_type res;
      xi = $signed(raw);
      mag = 64'(xi < 0 ? -xi : xi);
      sum_sq = 37'(sum_sq + mag * mag);
      vector_buf.push_back(raw);
      if (!last_flag && vector_buf.size() < MAX_LEN)
         return;
      n = vector_buf.size();
      do_scale = norm_en && (sum_sq != 0);
      norm_q20 = do_scale ? floor_sqrt({27'b0, sum_sq} << 16) : 64'd0;
      if (norm_q20 == 0)
         do_scale = 1'b0;
      for (int k = 0; k < n; k++) begin
         xi = $signed(vector_buf[k]);
         if (do_scale) begin
            mag = 64'(xi < 0 ? -xi : xi);
            quot = (mag << 23) / norm_q20;
            if (quot > 64'd32767)
               quot = 64'd32767;
            res.value = (xi < 0) ? -quot[VAL_W-1:0] : quot[VAL_W-1:0];
         end else begin
            res.value = vector_buf[k];
         end
         res.index = ADDR_W'(k);
         res.scaled = do_scale;
         res.last = (k == n - 1);
         result_due.push_back(res);
      end
      vector_buf.delete();
      sum_sq = '0;
   endtask

   // Element driver
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_gap <= 0;
      end else if (!(req_if.valid && !req_if.ready)) begin
         if (req_gap > 0) begin
            req_if.valid <= 1'b0;
            req_gap <= req_gap - 1;
         end else if (idle_on && $urandom_range(0, 9) == 0) begin
            req_if.valid <= 1'b0;
            req_gap <= $urandom_range(0, 5);
         end else if (element_queue.size() > 0) begin
            element_beat_type b;
            b = element_queue.pop_front();
            req_if.valid <= 1'b1;
            req_if.element_value <= b.value;
            req_if.last_element <= b.last;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Result sink backpressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rsp_stall <= 0;
      end else if (rsp_stall > 0) begin
         rsp_if.ready <= 1'b0;
         rsp_stall <= rsp_stall - 1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         rsp_if.ready <= 1'b0;
         rsp_stall <= $urandom_range(0, 5);
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   // Monitors: predict on accepted elements, check accepted results
   always @(posedge clock) begin
      if (!reset && req_if.valid && req_if.ready)
         absorb_element(req_if.element_value, req_if.last_element);
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (result_due.size() == 0) begin
            report_mismatch($sformatf("unexpected result beat idx %0d val %0d",
                                      rsp_if.result_index, rsp_if.result_value));
         end else begin
            norm_result_type e;
            e = result_due.pop_front();
            if (rsp_if.result_value !== e.value || rsp_if.result_index !== e.index ||
                rsp_if.was_scaled !== e.scaled || rsp_if.last_result !== e.last)
               report_mismatch($sformatf(
                  "got val %0d idx %0d sc %0b last %0b, exp val %0d idx %0d sc %0b last %0b",
                  rsp_if.result_value, rsp_if.result_index, rsp_if.was_scaled,
                  rsp_if.last_result, $signed(e.value), e.index, e.scaled, e.last));
         end
      end
   end

   task automatic push_element(input int value, input bit last_flag);
      element_beat_type b;
      b.value = VAL_W'(value);
      b.last = last_flag;
      element_queue.push_back(b);
   endtask

   task automatic queue_random_vectors(input int n_items);
      int queued;
      int len;
      int style;
      int v;
      bit last_flag;
      queued = 0;
      while (queued < n_items) begin
         case ($urandom_range(0, 9))
            0: len = MAX_LEN;
            1: len = $urandom_range(9, MAX_LEN - 1);
            default: len = $urandom_range(1, 8);
         endcase
         style = $urandom_range(0, 5);
         for (int i = 0; i < len; i++) begin
            case (style)
               0: v = 0;
               2: v = $urandom_range(0, 30) - 15;
               3: case ($urandom_range(0, 4))
                     0: v = 32767;
                     1: v = -32768;
                     2: v = 0;
                     3: v = 1;
                     default: v = -1;
                  endcase
               default: v = $signed(16'($urandom));
            endcase
            // a full buffer ends the vector with or without the flag
            last_flag = (i == len - 1) && !(len == MAX_LEN && $urandom_range(0, 1) == 0);
            push_element(v, last_flag);
         end
         queued += len;
      end
   endtask

   task automatic wait_drained;
      while (element_queue.size() != 0 || req_if.valid || result_due.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (addr == ENABLE_ADDR)
         norm_en = data[0];
   endtask

   task automatic csr_check_enable;
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= ENABLE_ADDR;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata[0] !== norm_en)
         report_mismatch($sformatf("enable readback %0b, exp %0b", prdata[0], norm_en));
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   initial begin
      req_if.valid = 1'b0;
      req_if.element_value = '0;
      req_if.last_element = 1'b0;
      rsp_if.ready = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // scaling on from reset: saturation, zero sum, exact ratios
      push_element(32767, 1);
      push_element(-32768, 1);
      push_element(0, 1);
      push_element(0, 0);
      push_element(0, 0);
      push_element(0, 1);
      push_element(1, 1);
      push_element(3, 0);
      push_element(-4, 1);
      push_element(32767, 0);
      push_element(-32768, 0);
      push_element(1, 0);
      push_element(-1, 0);
      push_element(0, 1);
      for (int i = 0; i < 4; i++)
         push_element(4096, i == 3);
      queue_random_vectors(120);
      wait_drained();

      // pass-through; junk in upper bits and a write to an unmapped index
      csr_write(ENABLE_ADDR, $urandom & ~32'd1);
      csr_write(SPARE_ADDR, $urandom);
      csr_check_enable();
      push_element(32767, 0);
      push_element(-32768, 0);
      push_element(0, 1);
      push_element(5, 0);
      push_element(-7, 1);
      queue_random_vectors(80);
      wait_drained();

      csr_write(ENABLE_ADDR, $urandom | 32'd1);
      csr_check_enable();
      queue_random_vectors(100);
      wait_drained();

      // closing stretch at full rate on both sides
      idle_on = 1'b0;
      queue_random_vectors(60);
      wait_drained();

      if (mismatches == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
